// ----- design/utf16_to_codepoint_lf_decoder_macros.svh -----
// assertion macros for the utf-16 to code point decoder
`ifndef UTF16_TO_CODEPOINT_LF_DECODER_MACROS_SVH
`define UTF16_TO_CODEPOINT_LF_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define U16CP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define U16CP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/u16cp_pkg.sv -----
// types and constants shared by the utf-16 to code point decoder
`default_nettype none

package u16cp_pkg;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CR   = 2'd1;
    localparam logic [1:0] KIND_HIGH = 2'd2;

    localparam logic [15:0] CH_CR = 16'h000D;
    localparam logic [15:0] CH_LF = 16'h000A;

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_last;
    } t_unit;

    typedef struct packed {
        logic [20:0] code_point;
        logic        point_last;
    } t_point;

    typedef struct packed {
        logic [1:0]  count;
        t_point      first;
        t_point      second;
        logic [1:0]  held_kind;
        logic [15:0] held_unit;
    } t_step;

    function automatic logic is_high(input logic [15:0] u);
        return u[15:10] == 6'b110110;
    endfunction

    function automatic logic is_low(input logic [15:0] u);
        return u[15:10] == 6'b110111;
    endfunction

endpackage

`default_nettype wire

// ----- design/utf16_to_codepoint_lf_decoder.sv -----
// top level of the utf-16 to code point decoder with crlf folding
//
// Takes one UTF-16 code unit per cycle while o_stall is low and returns decoded code
// points: surrogate pairs are combined, CR followed by LF becomes LF, and the last
// result of a string carries point_last. A CR or high surrogate is held one unit as
// lookahead, flushed by the unit flagged last. The unit goes through an input register,
// one step of logic and a two-entry result queue before its result appears. A unit
// that yields two code points takes both queue entries, and the input stalls while
// the queue lacks room for the results of a step.
`default_nettype none

module utf16_to_codepoint_lf_decoder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire u16cp_pkg::t_unit  i_unit,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      u16cp_pkg::t_point o_point
);

    `include "utf16_to_codepoint_lf_decoder_macros.svh"

    logic              r_in_valid;
    u16cp_pkg::t_unit  r_in;
    logic [1:0]        r_held_kind;
    logic [15:0]       r_held_unit;
    logic [1:0]        r_cnt;
    u16cp_pkg::t_point r_q0;
    u16cp_pkg::t_point r_q1;

    u16cp_pkg::t_step  step;
    logic              pop;
    logic              fire;
    logic [1:0]        base_cnt;
    logic [1:0]        push_cnt;
    logic [2:0]        total;
    u16cp_pkg::t_point base0;
    logic [1:0]        n_cnt;
    u16cp_pkg::t_point n_q0;
    u16cp_pkg::t_point n_q1;

    u16cp_step u_step (
        .i_held_kind (r_held_kind),
        .i_held_unit (r_held_unit),
        .i_unit      (r_in),
        .o_step      (step)
    );

    assign o_valid  = r_cnt != 2'd0;
    assign o_point  = r_q0;
    assign pop      = o_valid && !i_stall;
    assign base_cnt = r_cnt - {1'b0, pop};
    assign total    = {1'b0, base_cnt} + {1'b0, step.count};
    assign fire     = r_in_valid && (total <= 3'd2);
    assign o_stall  = r_in_valid && !fire;
    assign push_cnt = fire ? step.count : 2'd0;
    assign base0    = pop ? r_q1 : r_q0;

    always_comb begin
        n_cnt = base_cnt + push_cnt;
        unique case (base_cnt)
            2'd0: begin
                n_q0 = step.first;
                n_q1 = step.second;
            end
            2'd1: begin
                n_q0 = base0;
                n_q1 = step.first;
            end
            default: begin
                n_q0 = r_q0;
                n_q1 = r_q1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_held_kind <= u16cp_pkg::KIND_NONE;
            r_cnt       <= 2'd0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_held_kind <= step.held_kind;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_unit;
        end
        if (fire) begin
            r_held_unit <= step.held_unit;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    `U16CP_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt != 2'd3, "result queue overfilled")
    `U16CP_ASSERT_NOW(a_held_cr, r_held_kind == u16cp_pkg::KIND_CR,
        r_held_unit == u16cp_pkg::CH_CR, "held cr does not hold a cr")
    `U16CP_ASSERT_NOW(a_held_high, r_held_kind == u16cp_pkg::KIND_HIGH,
        u16cp_pkg::is_high(r_held_unit), "held unit is not a high surrogate")
    `U16CP_ASSERT_NEXT(a_last_flush, fire && r_in.unit_last,
        r_held_kind == u16cp_pkg::KIND_NONE, "unit held after the last transaction")

endmodule

`default_nettype wire

// ----- design/u16cp_step.sv -----
// one decode step: resolves the held unit against a new code unit
`default_nettype none

module u16cp_step (
    input  wire logic [1:0]       i_held_kind,
    input  wire logic [15:0]      i_held_unit,
    input  wire u16cp_pkg::t_unit i_unit,
    output u16cp_pkg::t_step      o_step
);

    logic [15:0]       u;
    logic              last;
    u16cp_pkg::t_point held_pt;
    u16cp_pkg::t_point own_pt;
    u16cp_pkg::t_point pair_pt;
    logic              resolved;
    logic              held_out;

    always_comb begin
        u        = i_unit.code_unit;
        last     = i_unit.unit_last;
        held_pt  = '{code_point: {5'd0, i_held_unit}, point_last: 1'b0};
        own_pt   = '{code_point: {5'd0, u}, point_last: last};
        pair_pt  = '{code_point: u16cp_pkg::SUPP_BASE
                                 + {1'b0, i_held_unit[9:0], u[9:0]},
                     point_last: last};
        resolved = 1'b0;
        held_out = 1'b0;
        o_step   = '0;

        unique case (i_held_kind)
            u16cp_pkg::KIND_CR: begin
                if (u == u16cp_pkg::CH_LF) begin
                    resolved = 1'b1;
                end else begin
                    held_out = 1'b1;
                end
            end
            u16cp_pkg::KIND_HIGH: begin
                if (u16cp_pkg::is_low(u)) begin
                    resolved = 1'b1;
                    own_pt   = pair_pt;
                end else begin
                    held_out = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // resolved pair or crlf: own_pt already carries the result
        if (resolved) begin
            o_step.count = 2'd1;
            o_step.first = own_pt;
        end else begin
            priority if (last || !(u == u16cp_pkg::CH_CR || u16cp_pkg::is_high(u))) begin
                if (held_out) begin
                    o_step.count  = 2'd2;
                    o_step.first  = held_pt;
                    o_step.second = own_pt;
                end else begin
                    o_step.count = 2'd1;
                    o_step.first = own_pt;
                end
            end else begin
                o_step.held_kind = (u == u16cp_pkg::CH_CR) ? u16cp_pkg::KIND_CR
                                                           : u16cp_pkg::KIND_HIGH;
                o_step.held_unit = u;
                if (held_out) begin
                    o_step.count = 2'd1;
                    o_step.first = held_pt;
                end
            end
        end
    end

endmodule

`default_nettype wire
